/* rtl/crc_checked_frame_receiver_unit_defines.svh */
// Assertion macros for the frame receiver.
`ifndef CRC_CHECKED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_UNIT_DEFINES_SVH
// check that a condition implies another on the same edge
`define CFR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
// check that a condition implies another on the next edge
`define CFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

/* rtl/cfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants and helpers for the frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;
	localparam int BUFFER_DEPTH_DEF = 512;
	localparam logic [7:0] START_SHORT = 8'd2;
	localparam logic [7:0] START_LONG = 8'd3;
	localparam logic [7:0] STOP_MARK = 8'd3;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic [6:0] frames_done;
		logic [7:0] last_command;
		logic [8:0] last_payload_length;
		logic [9:0] bad_start_count;
		logic [9:0] too_large_count;
		logic [9:0] bad_stop_count;
		logic [9:0] crc_fail_count;
		logic overflow_drop;
		logic [9:0] fill_level;
	} cfr_result_t;

	// one byte of CRC-16/XMODEM: eight dependent narrow steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction
endpackage

/* rtl/cfr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/cfr_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_scanner
// Sequencer that appends a byte, then rescans the buffer through the RAM.
// ----------------------------------------------------------------------------
module cfr_scanner #(
	parameter int BUFFER_DEPTH = cfr_pkg::BUFFER_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_byte,
	output logic res_valid,
	input logic res_ready,
	output cfr_pkg::cfr_result_t res,
	output logic busy
);
	import cfr_pkg::*;
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_START_RD, S_START, S_LEN1, S_LEN2, S_CHK, S_STOP, S_CRCH, S_CRCL,
		S_PAY, S_CMP, S_DONE
	} state_t;
	state_t state_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] raddr;
	logic [7:0] rdata;
	logic we;
	logic [AW-1:0] waddr;
	logic [7:0] start_q;
	logic [15:0] plen_q;
	logic [15:0] expect_q;
	logic [15:0] crc_q;
	logic [CW-1:0] idx_q;
	logic [7:0] cmd_q;
	logic [7:0] last_cmd_q;
	logic [15:0] last_plen_q;
	logic [16:0] flen_w;
	logic [1:0] hdr_w;
	logic [CW-1:0] hdr_c;
	logic [CW-1:0] plen_c;
	logic [CW-1:0] flen_c;
	logic [CW-1:0] fr_q, bs_q, tl_q, bp_q, cf_q;
	logic ovf_q;
	logic out_v_q;
	cfr_result_t res_q;

	cfr_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(in_byte),
		.raddr(raddr), .rdata(rdata)
	);

	// circular address: h is in range and o below the depth, so one subtract wraps
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h,
		input logic [CW-1:0] o);
		logic [CW:0] s;
		s = {2'b00, h} + {1'b0, o};
		if (s >= (CW+1)'(BUFFER_DEPTH)) s = s - (CW+1)'(BUFFER_DEPTH);
		return s[AW-1:0];
	endfunction

	// drop n bytes from the head; an emptied buffer restarts at entry zero
	function automatic logic [AW+CW-1:0] drop_front(input logic [AW-1:0] h,
		input logic [CW-1:0] c, input logic [CW-1:0] n);
		if (n >= c) return '0;
		return {wrap_add(h, n), c - n};
	endfunction

	function automatic logic [6:0] sat7(input logic [31:0] v);
		return (v > 32'd127) ? 7'h7F : v[6:0];
	endfunction

	function automatic logic [8:0] sat9(input logic [31:0] v);
		return (v > 32'd511) ? 9'h1FF : v[8:0];
	endfunction

	function automatic logic [9:0] sat10(input logic [31:0] v);
		return (v > 32'd1023) ? 10'h3FF : v[9:0];
	endfunction

	assign hdr_w = (start_q == START_SHORT) ? 2'd2 : 2'd3;
	assign flen_w = {15'd0, hdr_w} + {1'b0, plen_q} + 17'd3;
	assign hdr_c = {{(CW-2){1'b0}}, hdr_w};
	assign plen_c = plen_q[CW-1:0];
	assign flen_c = flen_w[CW-1:0];
	assign in_ready = (state_q == S_IDLE) && !out_v_q;
	assign busy = (state_q != S_IDLE);
	assign res_valid = out_v_q;
	assign res = res_q;

	// a full buffer overwrites its oldest entry
	assign we = in_valid && in_ready;
	assign waddr = (count_q >= DEPTH_C) ? head_q : wrap_add(head_q, count_q);

	// read address, issued in the cycle before the data is used
	always_comb begin
		case (state_q)
			S_START: raddr = wrap_add(head_q, CW'(1));
			S_LEN1: raddr = wrap_add(head_q, CW'(2));
			S_CHK: raddr = wrap_add(head_q, flen_c - CW'(1));
			S_STOP: raddr = wrap_add(head_q, hdr_c + plen_c);
			S_CRCH: raddr = wrap_add(head_q, hdr_c + plen_c + CW'(1));
			S_CRCL: raddr = wrap_add(head_q, hdr_c);
			S_PAY: raddr = wrap_add(head_q, hdr_c + idx_q + CW'(1));
			default: raddr = head_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			out_v_q <= 1'b0;
			fr_q <= '0; bs_q <= '0; tl_q <= '0; bp_q <= '0; cf_q <= '0;
			ovf_q <= 1'b0;
			start_q <= '0; plen_q <= '0; expect_q <= '0; crc_q <= '0;
			idx_q <= '0; cmd_q <= '0;
			last_cmd_q <= '0; last_plen_q <= '0;
			res_q <= '0;
		end else begin
			if (state_q == S_DONE) out_v_q <= 1'b1;
			else if (res_ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						fr_q <= '0; bs_q <= '0; tl_q <= '0; bp_q <= '0; cf_q <= '0;
						last_cmd_q <= '0; last_plen_q <= '0;
						if (count_q >= DEPTH_C) begin
							head_q <= wrap_add(head_q, CW'(1));
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
							ovf_q <= 1'b0;
						end
						state_q <= S_START_RD;
					end
				end
				S_START_RD: begin
					state_q <= (count_q == '0) ? S_DONE : S_START;
				end
				S_START: begin
					// rdata = head byte
					start_q <= rdata;
					if (rdata == START_SHORT) begin
						state_q <= (count_q < CW'(5)) ? S_DONE : S_LEN1;
					end else if (rdata == START_LONG) begin
						state_q <= (count_q < CW'(6)) ? S_DONE : S_LEN1;
					end else begin
						bs_q <= bs_q + CW'(1);
						{head_q, count_q} <= drop_front(head_q, count_q, CW'(1));
						state_q <= S_START_RD;
					end
				end
				S_LEN1: begin
					plen_q <= {8'd0, rdata};
					state_q <= (start_q == START_SHORT) ? S_CHK : S_LEN2;
				end
				S_LEN2: begin
					plen_q <= {plen_q[7:0], rdata};
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (flen_w > 17'(BUFFER_DEPTH)) begin
						tl_q <= tl_q + CW'(1);
						{head_q, count_q} <= drop_front(head_q, count_q, CW'(1));
						state_q <= S_START_RD;
					end else if ({{(17-CW){1'b0}}, count_q} < flen_w) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_STOP;
					end
				end
				S_STOP: begin
					// rdata = stop byte
					if (rdata != STOP_MARK) begin
						bp_q <= bp_q + CW'(1);
						{head_q, count_q} <= drop_front(head_q, count_q, CW'(1));
						state_q <= S_START_RD;
					end else begin
						state_q <= S_CRCH;
					end
				end
				S_CRCH: begin
					expect_q[15:8] <= rdata;
					state_q <= S_CRCL;
				end
				S_CRCL: begin
					expect_q[7:0] <= rdata;
					crc_q <= '0;
					idx_q <= '0;
					cmd_q <= '0;
					state_q <= (plen_q == 16'd0) ? S_CMP : S_PAY;
				end
				S_PAY: begin
					// rdata = payload byte idx_q
					crc_q <= crc_byte(crc_q, rdata);
					if (idx_q == '0) cmd_q <= rdata;
					idx_q <= idx_q + CW'(1);
					if (idx_q + CW'(1) == plen_c) state_q <= S_CMP;
				end
				S_CMP: begin
					if (expect_q != crc_q) begin
						cf_q <= cf_q + CW'(1);
						{head_q, count_q} <= drop_front(head_q, count_q, CW'(1));
					end else begin
						fr_q <= fr_q + CW'(1);
						last_plen_q <= plen_q;
						last_cmd_q <= cmd_q;
						{head_q, count_q} <= drop_front(head_q, count_q, flen_c);
					end
					state_q <= S_START_RD;
				end
				S_DONE: begin
					res_q.frames_done <= sat7(32'(fr_q));
					res_q.last_command <= last_cmd_q;
					res_q.last_payload_length <= sat9(32'(last_plen_q));
					res_q.bad_start_count <= sat10(32'(bs_q));
					res_q.too_large_count <= sat10(32'(tl_q));
					res_q.bad_stop_count <= sat10(32'(bp_q));
					res_q.crc_fail_count <= sat10(32'(cf_q));
					res_q.overflow_drop <= ovf_q;
					res_q.fill_level <= sat10(32'(count_q));
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/crc_checked_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_unit
// Length-prefixed frame receiver with CRC-16/XMODEM check.
// ----------------------------------------------------------------------------
// Each received byte is appended to a circular buffer RAM (the oldest byte is
// dropped first when the buffer is full) and the buffer is rescanned from its
// head. The scan reads one RAM byte per cycle: a start byte check reads the
// head byte, a frame is checked through its length, stop and CRC bytes and
// then its payload bytes, and every framing error drops the head byte and
// restarts the check. An incomplete frame or an emptied buffer ends the scan
// and the result is registered in the done state, so a byte that only waits
// passes through the start read and done states before its result is issued.
// No new byte is taken until the result of the previous one has been accepted.
module crc_checked_frame_receiver_unit #(
	parameter int BUFFER_DEPTH = cfr_pkg::BUFFER_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // [7:0] rx_byte
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [6:0] frames_done, [14:7] last_command, [23:15] last_payload_length,
	// [33:24] bad_start, [43:34] too_large, [53:44] bad_stop, [63:54] crc_fail,
	// [64] overflow_drop, [74:65] fill_level
	output logic [79:0] m_axis_tdata
);
	import cfr_pkg::*;
	`include "crc_checked_frame_receiver_unit_defines.svh"

	cfr_result_t res;
	logic busy;

	cfr_scanner #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_scan (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_byte(s_axis_tdata),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res), .busy(busy)
	);

	assign m_axis_tdata = {5'd0, res.fill_level, res.overflow_drop, res.crc_fail_count,
		res.bad_stop_count, res.too_large_count, res.bad_start_count,
		res.last_payload_length, res.last_command, res.frames_done};

	`CFR_ASSERT_IMP(a_no_accept_busy, busy, !s_axis_tready)
	`CFR_ASSERT_IMP(a_fill_bound, m_axis_tvalid, 32'(res.fill_level) <= 32'(BUFFER_DEPTH))
	`CFR_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule
